/* rtl/bmc_pkg.sv */
// shared types and constants for the backtracking maze carver
// no dependencies; used by every file under rtl but bmc_ram
`default_nettype none

package bmc_pkg;

  localparam int DEF_GRID_WIDTH  = 15;
  localparam int DEF_GRID_HEIGHT = 15;
  localparam int DEF_STACK_DEPTH = 64;

  // field widths fixed by the item formats
  localparam int FIELD_XY_W = 4;
  localparam int RAND_W     = 15;
  localparam int DEPTH_W    = 7;
  localparam int CFG_IDX_W  = 1;

  // floor(r / 3) == (r * RECIP3) >> 16 for every 15-bit r
  localparam int RECIP3 = 21846;

  typedef enum logic [1:0] {
    KIND_RESTART = 2'd0,
    KIND_ADVANCE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 1'b0,
    CFG_START_Y = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_START,
    S_LOAD,
    S_PROBE,
    S_PICK,
    S_MID,
    S_READ,
    S_RWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [RAND_W-1:0]     rand_value;
    logic [FIELD_XY_W-1:0] cell_x;
    logic [FIELD_XY_W-1:0] cell_y;
  } in_item_t;

  typedef struct packed {
    logic                  finished;
    logic                  carved;
    logic [FIELD_XY_W-1:0] carved_x;
    logic [FIELD_XY_W-1:0] carved_y;
    logic                  cell_is_path;
    logic [DEPTH_W-1:0]    stack_depth;
  } out_item_t;

  // coordinate width: enough for the grid and for the 4-bit item fields
  function automatic int coord_width(input int w, input int h);
    int m;
    int c;
    m = (w > h) ? w : h;
    c = $clog2(m);
    coord_width = (c < FIELD_XY_W) ? FIELD_XY_W : c;
  endfunction

endpackage

`default_nettype wire

/* rtl/backtracking_maze_carver.sv */
// Randomized depth-first maze carver on a GRID_WIDTH x GRID_HEIGHT wall/open grid.
// Input beats (in_valid/in_stall/in_data) carry a kind: restart, advance, read or no-op.
// Every input beat yields exactly one result beat on out_valid/out_stall/out_data.
// Start cell comes from two registers written on the cfg port (cfg_ready is always high),
// cfg_index 0 = start column, 1 = start row, both reset to 1; write only while idle.
// Steps from acceptance to the load of the result register, one item in flight at a time:
//   no-op or advance on an empty stack: straight to the result
//   read: one grid ram read
//   advance: stack read, four pipelined grid reads, pick, then, when a cell is carved,
//     two grid writes on the single write port; a pop writes nothing
//   restart: the grid ram is swept one cell per cycle, then the start cell is
//     written and pushed if it lies inside the grid
// After reset the block clears the whole grid with in_stall high; cfg writes
// are taken meanwhile.
// The next input beat is taken while a finished result still waits on a stalled
// output; a further result waits in its final state until the output register frees up.
// uses bmc_pkg, bmc_ctrl and bmc_ram
`default_nettype none

module backtracking_maze_carver #(
  parameter int GRID_WIDTH  = bmc_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = bmc_pkg::DEF_GRID_HEIGHT,
  parameter int STACK_DEPTH = bmc_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire bmc_pkg::in_item_t              in_data,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      bmc_pkg::out_item_t             out_data,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bmc_pkg::FIELD_XY_W-1:0] cfg_data
);

  localparam int CW    = bmc_pkg::coord_width(GRID_WIDTH, GRID_HEIGHT);
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int SAW   = $clog2(STACK_DEPTH);

  logic [bmc_pkg::FIELD_XY_W-1:0] start_x_r, start_x_nxt;
  logic [bmc_pkg::FIELD_XY_W-1:0] start_y_r, start_y_nxt;

  logic            grid_we;
  logic [AW-1:0]   grid_waddr;
  logic            grid_wdata;
  logic [AW-1:0]   grid_raddr;
  logic            grid_rdata;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr;
  logic [2*CW-1:0] stk_wdata;
  logic [SAW-1:0]  stk_raddr;
  logic [2*CW-1:0] stk_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    if (cfg_valid) begin
      case (bmc_pkg::cfg_idx_t'(cfg_index))
        bmc_pkg::CFG_START_X: start_x_nxt = cfg_data;
        bmc_pkg::CFG_START_Y: start_y_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= bmc_pkg::FIELD_XY_W'(1);
      start_y_r <= bmc_pkg::FIELD_XY_W'(1);
    end else begin
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
    end
  end

  bmc_ctrl #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .start_x    (start_x_r),
    .start_y    (start_y_r),
    .grid_we    (grid_we),
    .grid_waddr (grid_waddr),
    .grid_wdata (grid_wdata),
    .grid_raddr (grid_raddr),
    .grid_rdata (grid_rdata),
    .stk_we     (stk_we),
    .stk_waddr  (stk_waddr),
    .stk_wdata  (stk_wdata),
    .stk_raddr  (stk_raddr),
    .stk_rdata  (stk_rdata)
  );

  // one bit per cell, 1 = open path
  bmc_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  // positions as {row, column}
  bmc_ram #(
    .WIDTH (2 * CW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

`default_nettype wire

/* rtl/bmc_ram.sv */
// simple dual-port synchronous ram, one write and one registered read per cycle
// no dependencies; holds the grid bits and the position stack
`default_nettype none

module bmc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/bmc_ctrl.sv */
// sequencer of the maze carver: restart sweep, advance probe/pick, cell reads
// uses bmc_pkg; drives the grid and stack rams instantiated at the top level
`default_nettype none

module bmc_ctrl #(
  parameter int GRID_WIDTH  = bmc_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = bmc_pkg::DEF_GRID_HEIGHT,
  parameter int STACK_DEPTH = bmc_pkg::DEF_STACK_DEPTH,
  localparam int CW  = bmc_pkg::coord_width(GRID_WIDTH, GRID_HEIGHT),
  localparam int AW  = $clog2(GRID_WIDTH * GRID_HEIGHT),
  localparam int SAW = $clog2(STACK_DEPTH)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire bmc_pkg::in_item_t                  in_data,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      bmc_pkg::out_item_t                 out_data,
  input  wire logic [bmc_pkg::FIELD_XY_W-1:0]     start_x,
  input  wire logic [bmc_pkg::FIELD_XY_W-1:0]     start_y,
  output      logic                               grid_we,
  output      logic [AW-1:0]                      grid_waddr,
  output      logic                               grid_wdata,
  output      logic [AW-1:0]                      grid_raddr,
  input  wire logic                               grid_rdata,
  output      logic                               stk_we,
  output      logic [SAW-1:0]                     stk_waddr,
  output      logic [2*CW-1:0]                    stk_wdata,
  output      logic [SAW-1:0]                     stk_raddr,
  input  wire logic [2*CW-1:0]                    stk_rdata
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int SCW   = $clog2(STACK_DEPTH + 1);
  localparam int QW    = bmc_pkg::RAND_W - 1;
  localparam int PW    = 2 * bmc_pkg::RAND_W;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
    addr_of = AW'(int'(y) * GRID_WIDTH + int'(x));
  endfunction

  bmc_pkg::state_t    state_r, state_nxt;
  bmc_pkg::in_item_t  item_r, item_nxt;
  bmc_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SCW-1:0]     count_r, count_nxt;
  logic [CW-1:0]      cx_r, cx_nxt, cy_r, cy_nxt;
  logic [CW-1:0]      nx_r, nx_nxt, ny_r, ny_nxt;
  logic [CW-1:0]      mx_r, mx_nxt, my_r, my_nxt;
  logic [2:0]         probe_r, probe_nxt;
  logic [3:0]         cand_r, cand_nxt;
  logic [QW-1:0]      q3_r, q3_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               boot_r, boot_nxt;
  logic               carved_r, carved_nxt;
  logic               path_r, path_nxt;
  logic               rd_ok_r, rd_ok_nxt;

  // neighbor geometry, one lane per direction +x, -x, +y, -y
  logic [CW:0]   px [4];
  logic [CW:0]   py [4];
  logic [3:0]    inb;
  logic [2:0]    n_cand;
  logic [1:0]    rem;
  logic [1:0]    sel;
  logic [1:0]    prev_dir;
  logic [PW-1:0] prod;
  logic          start_ok;
  logic          cell_ok;

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      px[d] = {1'b0, cx_r};
      py[d] = {1'b0, cy_r};
      case (d)
        0:       px[d] = {1'b0, cx_r} + (CW+1)'(2);
        1:       px[d] = {1'b0, cx_r} - (CW+1)'(2);
        2:       py[d] = {1'b0, cy_r} + (CW+1)'(2);
        default: py[d] = {1'b0, cy_r} - (CW+1)'(2);
      endcase
      // a step below zero wraps to a large value and fails the upper bound
      inb[d] = (px[d] != '0) && (px[d] < (CW+1)'(GRID_WIDTH - 1)) &&
               (py[d] != '0) && (py[d] < (CW+1)'(GRID_HEIGHT - 1));
    end
  end

  // choose among the candidates: rand_value mod count, then the rem-th set bit
  always_comb begin
    logic [1:0] k;
    k      = '0;
    sel    = '0;
    n_cand = 3'(cand_r[0]) + 3'(cand_r[1]) + 3'(cand_r[2]) + 3'(cand_r[3]);
    case (n_cand)
      3'd2:    rem = {1'b0, item_r.rand_value[0]};
      3'd3:    rem = 2'(item_r.rand_value - bmc_pkg::RAND_W'(q3_r)
                        - bmc_pkg::RAND_W'({q3_r, 1'b0}));
      3'd4:    rem = item_r.rand_value[1:0];
      default: rem = '0;
    endcase
    for (int d = 0; d < 4; d++) begin
      if (cand_r[d]) begin
        if (k == rem) begin
          sel = 2'(d);
        end
        k = k + 2'd1;
      end
    end
  end

  assign prod     = PW'(item_r.rand_value) * PW'(bmc_pkg::RECIP3);
  assign prev_dir = 2'(probe_r - 3'd1);
  assign start_ok = (int'(start_x) < GRID_WIDTH) && (int'(start_y) < GRID_HEIGHT);
  assign cell_ok  = (int'(item_r.cell_x) < GRID_WIDTH) && (int'(item_r.cell_y) < GRID_HEIGHT);

  // top of stack is always read; it is stable from acceptance to the load state
  assign stk_raddr = SAW'(count_r - SCW'(1));

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    count_nxt     = count_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    probe_nxt     = probe_r;
    cand_nxt      = cand_r;
    q3_nxt        = q3_r;
    clr_addr_nxt  = clr_addr_r;
    boot_nxt      = boot_r;
    carved_nxt    = carved_r;
    path_nxt      = path_r;
    rd_ok_nxt     = rd_ok_r;
    grid_we       = 1'b0;
    grid_waddr    = '0;
    grid_wdata    = 1'b0;
    grid_raddr    = '0;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bmc_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          carved_nxt = 1'b0;
          path_nxt   = 1'b0;
          nx_nxt     = '0;
          ny_nxt     = '0;
          case (bmc_pkg::kind_t'(in_data.kind))
            bmc_pkg::KIND_RESTART: begin
              count_nxt    = '0;
              clr_addr_nxt = '0;
              state_nxt    = bmc_pkg::S_CLEAR;
            end
            bmc_pkg::KIND_ADVANCE: begin
              state_nxt = (count_r == '0) ? bmc_pkg::S_DONE : bmc_pkg::S_LOAD;
            end
            bmc_pkg::KIND_READ: state_nxt = bmc_pkg::S_READ;
            default:            state_nxt = bmc_pkg::S_DONE;
          endcase
        end
      end

      bmc_pkg::S_CLEAR: begin
        grid_we      = 1'b1;
        grid_waddr   = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(CELLS - 1)) begin
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? bmc_pkg::S_IDLE : bmc_pkg::S_START;
        end
      end

      bmc_pkg::S_START: begin
        if (start_ok) begin
          grid_we    = 1'b1;
          grid_waddr = addr_of(CW'(start_x), CW'(start_y));
          grid_wdata = 1'b1;
          stk_we     = 1'b1;
          stk_waddr  = '0;
          stk_wdata  = {CW'(start_y), CW'(start_x)};
          count_nxt  = SCW'(1);
        end
        state_nxt = bmc_pkg::S_DONE;
      end

      bmc_pkg::S_LOAD: begin
        cx_nxt    = stk_rdata[CW-1:0];
        cy_nxt    = stk_rdata[2*CW-1:CW];
        q3_nxt    = prod[PW-1:16];
        probe_nxt = '0;
        cand_nxt  = '0;
        state_nxt = bmc_pkg::S_PROBE;
      end

      // issue the read for direction probe_r, collect the one issued for the previous direction
      bmc_pkg::S_PROBE: begin
        if (probe_r != 3'd4 && inb[probe_r[1:0]]) begin
          grid_raddr = addr_of(CW'(px[probe_r[1:0]]), CW'(py[probe_r[1:0]]));
        end
        if (probe_r != 3'd0) begin
          cand_nxt[prev_dir] = inb[prev_dir] & ~grid_rdata;
        end
        probe_nxt = probe_r + 3'd1;
        if (probe_r == 3'd4) begin
          state_nxt = bmc_pkg::S_PICK;
        end
      end

      bmc_pkg::S_PICK: begin
        if (n_cand != 3'd0 && count_r < SCW'(STACK_DEPTH)) begin
          grid_we    = 1'b1;
          grid_waddr = addr_of(CW'(px[sel]), CW'(py[sel]));
          grid_wdata = 1'b1;
          stk_we     = 1'b1;
          stk_waddr  = SAW'(count_r);
          stk_wdata  = {CW'(py[sel]), CW'(px[sel])};
          count_nxt  = count_r + SCW'(1);
          carved_nxt = 1'b1;
          nx_nxt     = CW'(px[sel]);
          ny_nxt     = CW'(py[sel]);
          mx_nxt     = CW'(((CW+1)'({1'b0, cx_r}) + px[sel]) >> 1);
          my_nxt     = CW'(((CW+1)'({1'b0, cy_r}) + py[sel]) >> 1);
          state_nxt  = bmc_pkg::S_MID;
        end else begin
          count_nxt = count_r - SCW'(1);
          state_nxt = bmc_pkg::S_DONE;
        end
      end

      bmc_pkg::S_MID: begin
        grid_we    = 1'b1;
        grid_waddr = addr_of(mx_r, my_r);
        grid_wdata = 1'b1;
        state_nxt  = bmc_pkg::S_DONE;
      end

      bmc_pkg::S_READ: begin
        if (cell_ok) begin
          grid_raddr = addr_of(CW'(item_r.cell_x), CW'(item_r.cell_y));
        end
        rd_ok_nxt = cell_ok;
        state_nxt = bmc_pkg::S_RWAIT;
      end

      bmc_pkg::S_RWAIT: begin
        path_nxt  = rd_ok_r & grid_rdata;
        state_nxt = bmc_pkg::S_DONE;
      end

      bmc_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.finished     = (count_r == '0);
          out_nxt.carved       = carved_r;
          out_nxt.carved_x     = bmc_pkg::FIELD_XY_W'(nx_r);
          out_nxt.carved_y     = bmc_pkg::FIELD_XY_W'(ny_r);
          out_nxt.cell_is_path = path_r;
          out_nxt.stack_depth  = bmc_pkg::DEPTH_W'(count_r);
          out_valid_nxt        = 1'b1;
          state_nxt            = bmc_pkg::S_IDLE;
        end
      end

      default: state_nxt = bmc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmc_pkg::S_CLEAR;
      boot_r      <= 1'b1;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    out_r    <= out_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    nx_r     <= nx_nxt;
    ny_r     <= ny_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    probe_r  <= probe_nxt;
    cand_r   <= cand_nxt;
    q3_r     <= q3_nxt;
    carved_r <= carved_nxt;
    path_r   <= path_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

  assign in_stall  = (state_r != bmc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* dv/backtracking_maze_carver_tb.sv */
// self-checking bench for backtracking_maze_carver: directed table, then random carving runs
// keeps its own grid/stack model and compares every result beat field by field
// depends on bmc_pkg and the rtl under rtl/
module backtracking_maze_carver_tb;
  import bmc_pkg::*;

  localparam int GW        = DEF_GRID_WIDTH;
  localparam int GH        = DEF_GRID_HEIGHT;
  localparam int TRAIL_MAX = DEF_STACK_DEPTH;
  localparam int PHASES    = 9;
  localparam int PHASE_BEATS = 225;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [FIELD_XY_W-1:0] cfg_data = '0;

  backtracking_maze_carver u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // model of the maze: open cells, carve trail and start cell
  bit       maze_open [0:GW*GH-1];
  bit [3:0] trail_x [0:TRAIL_MAX-1];
  bit [3:0] trail_y [0:TRAIL_MAX-1];
  int       trail_len = 0;
  int       start_col = 1;
  int       start_row = 1;

  out_item_t maze_replies [$];
  out_item_t reply_due;

  int gap_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int n_sent = 0;
  int n_restart = 0;
  int n_checked = 0;
  int n_carved = 0;
  int n_settings = 0;

  typedef struct {
    bit        set_start;
    int        sx;
    int        sy;
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  plan_row_t plan [$];

  int phase_col [0:PHASES-1] = '{1, 13, 7, 13, 1, 15, 0, 9, 3};
  int phase_row [0:PHASES-1] = '{1, 13, 3, 1, 13, 5, 14, 11, 7};

  function automatic out_item_t reply(input bit fin, input bit carved, input int cx, input int cy,
                                      input bit path, input int depth);
    out_item_t r;
    r.finished     = fin;
    r.carved       = carved;
    r.carved_x     = cx[FIELD_XY_W-1:0];
    r.carved_y     = cy[FIELD_XY_W-1:0];
    r.cell_is_path = path;
    r.stack_depth  = depth[DEPTH_W-1:0];
    return r;
  endfunction

  // one step of the carving loop on the model; returns the result it produces
  function automatic out_item_t carve_predict(input in_item_t it);
    out_item_t r;
    int cx, cy, x, y, n, pick, d, rx, ry;
    int nx [4];
    int ny [4];
    r  = '0;
    rx = int'(it.cell_x);
    ry = int'(it.cell_y);
    case (it.kind)
      KIND_RESTART: begin
        foreach (maze_open[i]) maze_open[i] = 1'b0;
        trail_len = 0;
        if (start_col < GW && start_row < GH) begin
          maze_open[start_row*GW + start_col] = 1'b1;
          trail_x[0] = start_col[3:0];
          trail_y[0] = start_row[3:0];
          trail_len = 1;
        end
      end
      KIND_ADVANCE: begin
        if (trail_len > 0) begin
          cx = int'(trail_x[trail_len-1]);
          cy = int'(trail_y[trail_len-1]);
          n  = 0;
          // neighbor order: +x, -x, +y, -y
          for (d = 0; d < 4; d++) begin
            x = cx;
            y = cy;
            case (d)
              0: x = cx + 2;
              1: x = cx - 2;
              2: y = cy + 2;
              default: y = cy - 2;
            endcase
            if (x > 0 && x < GW-1 && y > 0 && y < GH-1 && !maze_open[y*GW + x]) begin
              nx[n] = x;
              ny[n] = y;
              n++;
            end
          end
          if (n > 0 && trail_len < TRAIL_MAX) begin
            pick = int'(it.rand_value) % n;
            x = nx[pick];
            y = ny[pick];
            maze_open[y*GW + x] = 1'b1;
            maze_open[((cy + y) / 2)*GW + (cx + x) / 2] = 1'b1;
            trail_x[trail_len] = x[3:0];
            trail_y[trail_len] = y[3:0];
            trail_len++;
            r.carved   = 1'b1;
            r.carved_x = x[3:0];
            r.carved_y = y[3:0];
          end else begin
            trail_len--;
          end
        end
      end
      KIND_READ: begin
        if (rx < GW && ry < GH) r.cell_is_path = maze_open[ry*GW + rx];
      end
      default: ;
    endcase
    r.finished    = (trail_len == 0);
    r.stack_depth = trail_len[DEPTH_W-1:0];
    return r;
  endfunction

  function automatic void plan_add(input bit set_start, input int sx, input int sy,
                                   input kind_t k, input int rv, input int cx, input int cy,
                                   input bit typed, input out_item_t want);
    plan_row_t row;
    row.set_start       = set_start;
    row.sx              = sx;
    row.sy              = sy;
    row.item.kind       = k;
    row.item.rand_value = rv[RAND_W-1:0];
    row.item.cell_x     = cx[FIELD_XY_W-1:0];
    row.item.cell_y     = cy[FIELD_XY_W-1:0];
    row.typed           = typed;
    row.want            = want;
    plan = {plan, row};
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d want %0d", n_checked, what, got, want);
    error_count++;
  endtask

  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t guess;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    guess = carve_predict(it);
    maze_replies = {maze_replies, (typed ? want : guess)};
    n_sent++;
    if (it.kind == KIND_RESTART) n_restart++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (maze_replies.size() != 0) @(posedge clk);
  endtask

  // both start registers in one burst so cfg_valid stays high between the beats
  task automatic load_start(input int sx, input int sy);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_START_X;
    cfg_data  <= sx[FIELD_XY_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    start_col = sx;
    cfg_index <= CFG_START_Y;
    cfg_data  <= sy[FIELD_XY_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    start_row = sy;
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (maze_replies.size() == 0) begin
        flag_mismatch("result beat with nothing pending, finished", out_data.finished, 0);
      end else begin
        reply_due = maze_replies.pop_front();
        if (out_data.finished != reply_due.finished)
          flag_mismatch("finished", out_data.finished, reply_due.finished);
        if (out_data.carved != reply_due.carved)
          flag_mismatch("carved", out_data.carved, reply_due.carved);
        if (out_data.carved_x != reply_due.carved_x)
          flag_mismatch("carved_x", out_data.carved_x, reply_due.carved_x);
        if (out_data.carved_y != reply_due.carved_y)
          flag_mismatch("carved_y", out_data.carved_y, reply_due.carved_y);
        if (out_data.cell_is_path != reply_due.cell_is_path)
          flag_mismatch("cell_is_path", out_data.cell_is_path, reply_due.cell_is_path);
        if (out_data.stack_depth != reply_due.stack_depth)
          flag_mismatch("stack_depth", out_data.stack_depth, reply_due.stack_depth);
        if (out_data.carved) n_carved++;
      end
      n_checked++;
    end
  end

  initial begin
    #10_000_000;
    $display("backtracking_maze_carver regression: fail");
    $finish;
  end

  initial begin
    in_item_t it;
    int       p;
    int       useful;
    int       roll;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // grid untouched after reset, then the default start cell (1,1)
    plan_add(0, 0, 0, KIND_READ, 0, 0, 0, 1, reply(1, 0, 0, 0, 0, 0));
    plan_add(0, 0, 0, KIND_ADVANCE, 0, 0, 0, 1, reply(1, 0, 0, 0, 0, 0));
    plan_add(0, 0, 0, KIND_NOP, 32767, 15, 15, 1, reply(1, 0, 0, 0, 0, 0));
    plan_add(0, 0, 0, KIND_RESTART, 0, 0, 0, 1, reply(0, 0, 0, 0, 0, 1));
    plan_add(0, 0, 0, KIND_READ, 0, 1, 1, 1, reply(0, 0, 0, 0, 1, 1));
    plan_add(0, 0, 0, KIND_READ, 0, 15, 15, 1, reply(0, 0, 0, 0, 0, 1));
    plan_add(0, 0, 0, KIND_ADVANCE, 0, 0, 0, 1, reply(0, 1, 3, 1, 0, 2));
    plan_add(0, 0, 0, KIND_READ, 0, 2, 1, 1, reply(0, 0, 0, 0, 1, 2));
    plan_add(0, 0, 0, KIND_ADVANCE, 32767, 0, 0, 0, '0);
    plan_add(0, 0, 0, KIND_READ, 0, 14, 14, 0, '0);
    // start cell outside the grid: grid cleared, stack left empty
    plan_add(1, 15, 1, KIND_RESTART, 0, 0, 0, 1, reply(1, 0, 0, 0, 0, 0));
    plan_add(0, 0, 0, KIND_ADVANCE, 0, 0, 0, 1, reply(1, 0, 0, 0, 0, 0));
    plan_add(0, 0, 0, KIND_READ, 0, 1, 1, 1, reply(1, 0, 0, 0, 0, 0));
    plan_add(1, 1, 15, KIND_RESTART, 0, 0, 0, 1, reply(1, 0, 0, 0, 0, 0));
    // corner starts on the border have no neighbor inside and pop at once; an inner corner start carves
    plan_add(1, 0, 0, KIND_RESTART, 0, 0, 0, 1, reply(0, 0, 0, 0, 0, 1));
    plan_add(0, 0, 0, KIND_READ, 0, 0, 0, 1, reply(0, 0, 0, 0, 1, 1));
    plan_add(0, 0, 0, KIND_ADVANCE, 1, 0, 0, 1, reply(1, 0, 0, 0, 0, 0));
    plan_add(1, 14, 14, KIND_RESTART, 0, 0, 0, 1, reply(0, 0, 0, 0, 0, 1));
    plan_add(0, 0, 0, KIND_ADVANCE, 2, 0, 0, 1, reply(1, 0, 0, 0, 0, 0));
    plan_add(1, 13, 13, KIND_RESTART, 0, 0, 0, 1, reply(0, 0, 0, 0, 0, 1));
    plan_add(0, 0, 0, KIND_ADVANCE, 5, 0, 0, 0, '0);
    // even start cell
    plan_add(1, 2, 2, KIND_RESTART, 0, 0, 0, 1, reply(0, 0, 0, 0, 0, 1));
    plan_add(0, 0, 0, KIND_ADVANCE, 16384, 0, 0, 0, '0);
    plan_add(0, 0, 0, KIND_READ, 0, 2, 2, 0, '0);
    plan_add(0, 0, 0, KIND_NOP, 0, 0, 0, 0, '0);

    gap_pct   = 20;
    stall_pct = 64;
    foreach (plan[i]) begin
      if (plan[i].set_start) begin
        drain_replies();
        load_start(plan[i].sx, plan[i].sy);
      end
      send_beat(plan[i].item, plan[i].typed, plan[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      case (p / 3)
        0: begin gap_pct = 20; stall_pct = 64; end
        1: begin gap_pct = 64; stall_pct = 20; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      drain_replies();
      load_start(phase_col[p], phase_row[p]);
      useful = 0;
      it = '0;
      it.kind = KIND_RESTART;
      send_beat(it, 0, '0);
      while (useful < PHASE_BEATS) begin
        it.rand_value = RAND_W'($urandom);
        it.cell_x     = FIELD_XY_W'($urandom_range(15));
        it.cell_y     = FIELD_XY_W'($urandom_range(15));
        roll = $urandom_range(99);
        // mostly advances so mazes run to completion; restart soon after a maze is done
        if (trail_len == 0 && roll < 50) it.kind = KIND_RESTART;
        else if (roll < 3)               it.kind = KIND_RESTART;
        else if (roll < 73)              it.kind = KIND_ADVANCE;
        else if (roll < 93)              it.kind = KIND_READ;
        else                             it.kind = KIND_NOP;
        if (it.kind != KIND_NOP && !(it.kind == KIND_ADVANCE && trail_len == 0)) useful++;
        send_beat(it, 0, '0);
      end
    end

    drain_replies();
    repeat (20) @(posedge clk);
    $display("sent %0d input beats (%0d restarts) over %0d start cell settings",
             n_sent, n_restart, n_settings);
    $display("checked %0d result beats, %0d carving steps, %0d mismatches",
             n_checked, n_carved, error_count);
    if (error_count == 0) begin
      $display("backtracking_maze_carver regression: pass");
    end else begin
      $display("backtracking_maze_carver regression: fail");
    end
    $finish;
  end

endmodule
